// ===== design/kslf_pkg.sv =====
// Shared types, constants and sequencer states for the spanning forest labeler.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package kslf_pkg;

    localparam int MAX_EDGES_DEF = 64;
    localparam int MAX_NODES_DEF = 128;
    localparam int COORD_W       = 32;
    localparam int LEN_W         = 32;
    localparam int IDX_W         = 6;
    localparam int LBL_W         = 7;
    localparam int IN_DATA_W     = 160;
    localparam int OUT_DATA_W    = 16;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOOK,
        S_LOOK_CMP,
        S_ADD,
        S_ADD2,
        S_CHK,
        S_SCAN_INIT,
        S_SCAN,
        S_SCAN_CMP,
        S_KR_ORD,
        S_KR_SLOT,
        S_KR_WAIT,
        S_KR_UV,
        S_FIND,
        S_FIND_CHK,
        S_LB_ORD,
        S_LB_SLOT,
        S_LB_TREE,
        S_LB_U,
        S_LB_MAP,
        S_LB_SET,
        S_OUT_RD,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        FIND_U,
        FIND_V,
        FIND_L
    } find_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [LEN_W-1:0]          edge_length;
        logic                      curve_absent;
        logic                      last_curve;
    } curve_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] curve_index;
        logic [LBL_W-1:0] component_id;
        logic             overflow_flag;
        logic             last_result;
    } result_t;

endpackage

// ===== design/kslf_engine.sv =====
// Sequencer, batch memories and shared compare path of the spanning forest labeler.
// Depends on kslf_pkg for the item and result structs and the state encoding.
`timescale 1ns / 1ps

module kslf_engine #(
    parameter int MAX_EDGES = kslf_pkg::MAX_EDGES_DEF,
    parameter int MAX_NODES = kslf_pkg::MAX_NODES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kslf_pkg::curve_t  in_item,
    input  logic              res_ready,
    output kslf_pkg::result_t res
);

    localparam int EW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int KEY_W = kslf_pkg::LEN_W + EW;
    localparam int LW    = kslf_pkg::LBL_W;
    localparam int CW    = 2 * kslf_pkg::COORD_W;

    kslf_pkg::state_t state_reg, state_next;
    kslf_pkg::find_t  fsel_reg, fsel_next;
    kslf_pkg::curve_t item_reg, item_next;

    logic [EW:0]          curve_cnt_reg, curve_cnt_next;
    logic [NW:0]          node_cnt_reg, node_cnt_next;
    logic                 ovf_reg, ovf_next;
    logic [LW-1:0]        next_label_reg, next_label_next;
    logic [MAX_EDGES-1:0] ok_reg, ok_next;
    logic [MAX_EDGES-1:0] tree_reg, tree_next;
    logic [MAX_NODES-1:0] pvalid_reg, pvalid_next;
    logic [MAX_NODES-1:0] mvalid_reg, mvalid_next;

    logic [EW-1:0]  slot_reg, slot_next;
    logic [NW:0]    look_reg, look_next;
    logic           sf_reg, sf_next, ef_reg, ef_next;
    logic [NW-1:0]  s_id_reg, s_id_next, e_id_reg, e_id_next;
    logic [EW:0]    k_reg, k_next, sorted_reg, sorted_next, j_reg, j_next;
    logic           has_prev_reg, has_prev_next, has_best_reg, has_best_next;
    logic [KEY_W-1:0] prev_reg, prev_next, best_reg, best_next;
    logic [NW-1:0]  v_reg, v_next, ru_reg, ru_next, cur_reg, cur_next;
    logic [NW-1:0]  root_reg, root_next;

    // Memories and their registered read data.
    logic [CW-1:0]              coord_mem [MAX_NODES];
    logic [kslf_pkg::LEN_W-1:0] weight_mem [MAX_EDGES];
    logic [EW-1:0]              ord_mem [MAX_EDGES];
    logic [2*NW-1:0]            edge_mem [MAX_EDGES];
    logic [NW-1:0]              par_mem [MAX_NODES];
    logic [LW-1:0]              map_mem [MAX_NODES];
    logic [LW-1:0]              lab_mem [MAX_EDGES];

    logic [CW-1:0]              coord_q;
    logic [kslf_pkg::LEN_W-1:0] weight_q;
    logic [EW-1:0]              ord_q;
    logic [2*NW-1:0]            edge_q;
    logic [NW-1:0]              par_q;
    logic [LW-1:0]              map_q, lab_q;
    logic                       pv_q, mv_q, lv_q;

    logic          coord_we, weight_we, ord_we, edge_we, par_we, map_we, lab_we;
    logic [NW-1:0] coord_wa;
    logic [CW-1:0] coord_wd;
    logic [NW-1:0] e_id_sel;
    logic [LW-1:0] lbl_sel;
    logic [NW-1:0] par_sel;
    logic [NW+1:0] need_total;
    logic [KEY_W-1:0] cand_key;
    logic [CW-1:0] skey, ekey;

    assign skey     = {item_reg.start_x, item_reg.start_y};
    assign ekey     = {item_reg.end_x, item_reg.end_y};
    assign cand_key = {weight_q, j_reg[EW-1:0]};
    assign in_ready = (state_reg == kslf_pkg::S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        fsel_next       = fsel_reg;
        item_next       = item_reg;
        curve_cnt_next  = curve_cnt_reg;
        node_cnt_next   = node_cnt_reg;
        ovf_next        = ovf_reg;
        next_label_next = next_label_reg;
        ok_next         = ok_reg;
        tree_next       = tree_reg;
        pvalid_next     = pvalid_reg;
        mvalid_next     = mvalid_reg;
        slot_next       = slot_reg;
        look_next       = look_reg;
        sf_next         = sf_reg;
        ef_next         = ef_reg;
        s_id_next       = s_id_reg;
        e_id_next       = e_id_reg;
        k_next          = k_reg;
        sorted_next     = sorted_reg;
        j_next          = j_reg;
        has_prev_next   = has_prev_reg;
        has_best_next   = has_best_reg;
        prev_next       = prev_reg;
        best_next       = best_reg;
        v_next          = v_reg;
        ru_next         = ru_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        coord_we        = 1'b0;
        coord_wa        = node_cnt_reg[NW-1:0];
        coord_wd        = skey;
        weight_we       = 1'b0;
        ord_we          = 1'b0;
        edge_we         = 1'b0;
        par_we          = 1'b0;
        map_we          = 1'b0;
        lab_we          = 1'b0;
        res             = '0;
        e_id_sel        = ef_reg ? e_id_reg : node_cnt_reg[NW-1:0];
        lbl_sel         = mv_q ? map_q : next_label_reg + LW'(1);
        par_sel         = pv_q ? par_q : cur_reg;
        need_total      = (NW+2)'(node_cnt_reg) + (NW+2)'(!sf_reg) + (NW+2)'(!ef_reg);

        unique case (state_reg)
            kslf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                    if (curve_cnt_reg == (EW+1)'(MAX_EDGES))
                    begin
                        ovf_next   = 1'b1;
                        state_next = kslf_pkg::S_CHK;
                    end
                    else
                    begin
                        slot_next      = curve_cnt_reg[EW-1:0];
                        weight_we      = 1'b1;
                        curve_cnt_next = curve_cnt_reg + (EW+1)'(1);
                        look_next      = '0;
                        sf_next        = 1'b0;
                        ef_next        = 1'b0;
                        if (in_item.curve_absent ||
                            ({in_item.start_x, in_item.start_y} ==
                             {in_item.end_x, in_item.end_y}))
                            state_next = kslf_pkg::S_CHK;
                        else
                            state_next = kslf_pkg::S_LOOK;
                    end
                end
            end
            kslf_pkg::S_LOOK:
            begin
                if (look_reg == node_cnt_reg)
                    state_next = kslf_pkg::S_ADD;
                else
                    state_next = kslf_pkg::S_LOOK_CMP;
            end
            kslf_pkg::S_LOOK_CMP:
            begin
                if (coord_q == skey && !sf_reg)
                begin
                    sf_next   = 1'b1;
                    s_id_next = look_reg[NW-1:0];
                end
                if (coord_q == ekey && !ef_reg)
                begin
                    ef_next   = 1'b1;
                    e_id_next = look_reg[NW-1:0];
                end
                look_next  = look_reg + (NW+1)'(1);
                state_next = kslf_pkg::S_LOOK;
            end
            kslf_pkg::S_ADD:
            begin
                if (need_total > (NW+2)'(MAX_NODES))
                begin
                    ovf_next   = 1'b1;
                    state_next = kslf_pkg::S_CHK;
                end
                else
                begin
                    if (!sf_reg)
                    begin
                        coord_we      = 1'b1;
                        coord_wd      = skey;
                        s_id_next     = node_cnt_reg[NW-1:0];
                        node_cnt_next = node_cnt_reg + (NW+1)'(1);
                    end
                    state_next = kslf_pkg::S_ADD2;
                end
            end
            kslf_pkg::S_ADD2:
            begin
                if (!ef_reg)
                begin
                    coord_we      = 1'b1;
                    coord_wd      = ekey;
                    node_cnt_next = node_cnt_reg + (NW+1)'(1);
                end
                edge_we           = 1'b1;
                ok_next[slot_reg] = 1'b1;
                state_next        = kslf_pkg::S_CHK;
            end
            kslf_pkg::S_CHK:
            begin
                if (item_reg.last_curve)
                begin
                    k_next        = '0;
                    has_prev_next = 1'b0;
                    state_next    = kslf_pkg::S_SCAN_INIT;
                end
                else
                    state_next = kslf_pkg::S_IDLE;
            end
            kslf_pkg::S_SCAN_INIT:
            begin
                j_next        = '0;
                has_best_next = 1'b0;
                state_next    = kslf_pkg::S_SCAN;
            end
            kslf_pkg::S_SCAN:
            begin
                if (j_reg == curve_cnt_reg)
                begin
                    if (has_best_reg)
                    begin
                        ord_we        = 1'b1;
                        prev_next     = best_reg;
                        has_prev_next = 1'b1;
                        k_next        = k_reg + (EW+1)'(1);
                        state_next    = kslf_pkg::S_SCAN_INIT;
                    end
                    else
                    begin
                        sorted_next = k_reg;
                        k_next      = '0;
                        state_next  = kslf_pkg::S_KR_ORD;
                    end
                end
                else
                    state_next = kslf_pkg::S_SCAN_CMP;
            end
            kslf_pkg::S_SCAN_CMP:
            begin
                // Length with slot number appended, so equal lengths sort by input order.
                if (ok_reg[j_reg[EW-1:0]] && (!has_prev_reg || cand_key > prev_reg) &&
                    (!has_best_reg || cand_key < best_reg))
                begin
                    best_next     = cand_key;
                    has_best_next = 1'b1;
                end
                j_next     = j_reg + (EW+1)'(1);
                state_next = kslf_pkg::S_SCAN;
            end
            kslf_pkg::S_KR_ORD:
            begin
                if (k_reg == sorted_reg)
                begin
                    k_next     = '0;
                    state_next = kslf_pkg::S_LB_ORD;
                end
                else
                    state_next = kslf_pkg::S_KR_SLOT;
            end
            kslf_pkg::S_KR_SLOT:
            begin
                slot_next  = ord_q;
                state_next = kslf_pkg::S_KR_WAIT;
            end
            kslf_pkg::S_KR_WAIT:
            begin
                state_next = kslf_pkg::S_KR_UV;
            end
            kslf_pkg::S_KR_UV:
            begin
                cur_next   = edge_q[2*NW-1:NW];
                v_next     = edge_q[NW-1:0];
                fsel_next  = kslf_pkg::FIND_U;
                state_next = kslf_pkg::S_FIND;
            end
            kslf_pkg::S_FIND:
            begin
                state_next = kslf_pkg::S_FIND_CHK;
            end
            kslf_pkg::S_FIND_CHK:
            begin
                if (par_sel != cur_reg)
                begin
                    cur_next   = par_sel;
                    state_next = kslf_pkg::S_FIND;
                end
                else
                begin
                    unique case (fsel_reg)
                        kslf_pkg::FIND_U:
                        begin
                            ru_next    = cur_reg;
                            cur_next   = v_reg;
                            fsel_next  = kslf_pkg::FIND_V;
                            state_next = kslf_pkg::S_FIND;
                        end
                        kslf_pkg::FIND_V:
                        begin
                            if (ru_reg != cur_reg)
                            begin
                                par_we              = 1'b1;
                                pvalid_next[ru_reg] = 1'b1;
                                tree_next[slot_reg] = 1'b1;
                            end
                            k_next     = k_reg + (EW+1)'(1);
                            state_next = kslf_pkg::S_KR_ORD;
                        end
                        default:
                        begin
                            root_next  = cur_reg;
                            state_next = kslf_pkg::S_LB_MAP;
                        end
                    endcase
                end
            end
            kslf_pkg::S_LB_ORD:
            begin
                if (k_reg == sorted_reg)
                begin
                    j_next     = '0;
                    state_next = kslf_pkg::S_OUT_RD;
                end
                else
                    state_next = kslf_pkg::S_LB_SLOT;
            end
            kslf_pkg::S_LB_SLOT:
            begin
                slot_next  = ord_q;
                state_next = kslf_pkg::S_LB_TREE;
            end
            kslf_pkg::S_LB_TREE:
            begin
                if (tree_reg[slot_reg])
                    state_next = kslf_pkg::S_LB_U;
                else
                begin
                    k_next     = k_reg + (EW+1)'(1);
                    state_next = kslf_pkg::S_LB_ORD;
                end
            end
            kslf_pkg::S_LB_U:
            begin
                cur_next   = edge_q[2*NW-1:NW];
                fsel_next  = kslf_pkg::FIND_L;
                state_next = kslf_pkg::S_FIND;
            end
            kslf_pkg::S_LB_MAP:
            begin
                state_next = kslf_pkg::S_LB_SET;
            end
            kslf_pkg::S_LB_SET:
            begin
                if (!mv_q)
                begin
                    map_we                = 1'b1;
                    mvalid_next[root_reg] = 1'b1;
                    next_label_next       = lbl_sel;
                end
                lab_we     = 1'b1;
                k_next     = k_reg + (EW+1)'(1);
                state_next = kslf_pkg::S_LB_ORD;
            end
            kslf_pkg::S_OUT_RD:
            begin
                state_next = kslf_pkg::S_OUT;
            end
            kslf_pkg::S_OUT:
            begin
                if (res_ready)
                begin
                    res.valid         = 1'b1;
                    res.curve_index   = kslf_pkg::IDX_W'(j_reg[EW-1:0]);
                    res.component_id  = lv_q ? lab_q : '0;
                    res.overflow_flag = ovf_reg;
                    res.last_result   = (j_reg == curve_cnt_reg - (EW+1)'(1));
                    if (j_reg == curve_cnt_reg - (EW+1)'(1))
                    begin
                        // End of batch: counts, flags and valid bits to reset values.
                        curve_cnt_next  = '0;
                        node_cnt_next   = '0;
                        ovf_next        = 1'b0;
                        next_label_next = '0;
                        ok_next         = '0;
                        tree_next       = '0;
                        pvalid_next     = '0;
                        mvalid_next     = '0;
                        state_next      = kslf_pkg::S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + (EW+1)'(1);
                        state_next = kslf_pkg::S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = kslf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kslf_pkg::S_IDLE;
            fsel_reg       <= kslf_pkg::FIND_U;
            curve_cnt_reg  <= '0;
            node_cnt_reg   <= '0;
            ovf_reg        <= 1'b0;
            next_label_reg <= '0;
            ok_reg         <= '0;
            tree_reg       <= '0;
            pvalid_reg     <= '0;
            mvalid_reg     <= '0;
            look_reg       <= '0;
            k_reg          <= '0;
            sorted_reg     <= '0;
            j_reg          <= '0;
            has_prev_reg   <= 1'b0;
            has_best_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fsel_reg       <= fsel_next;
            curve_cnt_reg  <= curve_cnt_next;
            node_cnt_reg   <= node_cnt_next;
            ovf_reg        <= ovf_next;
            next_label_reg <= next_label_next;
            ok_reg         <= ok_next;
            tree_reg       <= tree_next;
            pvalid_reg     <= pvalid_next;
            mvalid_reg     <= mvalid_next;
            look_reg       <= look_next;
            k_reg          <= k_next;
            sorted_reg     <= sorted_next;
            j_reg          <= j_next;
            has_prev_reg   <= has_prev_next;
            has_best_reg   <= has_best_next;
        end
    end

    // Every tree edge gets its label written, so the tree bit marks a valid label entry.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        slot_reg <= slot_next;
        sf_reg   <= sf_next;
        ef_reg   <= ef_next;
        s_id_reg <= s_id_next;
        e_id_reg <= e_id_next;
        prev_reg <= prev_next;
        best_reg <= best_next;
        v_reg    <= v_next;
        ru_reg   <= ru_next;
        cur_reg  <= cur_next;
        root_reg <= root_next;
        pv_q     <= pvalid_reg[cur_reg];
        mv_q     <= mvalid_reg[root_reg];
        lv_q     <= tree_reg[j_reg[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (coord_we)
            coord_mem[coord_wa] <= coord_wd;
        coord_q <= coord_mem[look_reg[NW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (weight_we)
            weight_mem[curve_cnt_reg[EW-1:0]] <= in_item.edge_length;
        weight_q <= weight_mem[j_reg[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[k_reg[EW-1:0]] <= best_reg[EW-1:0];
        ord_q <= ord_mem[k_reg[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[slot_reg] <= {s_id_reg, e_id_sel};
        edge_q <= edge_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[ru_reg] <= cur_reg;
        par_q <= par_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[root_reg] <= lbl_sel;
        map_q <= map_mem[root_reg];
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
            lab_mem[slot_reg] <= lbl_sel;
        lab_q <= lab_mem[j_reg[EW-1:0]];
    end

endmodule

// ===== design/kruskal_spanning_forest_labeler_top.sv =====
// Top level of the spanning forest labeler: stream ports and the result register.
// Depends on kslf_pkg and kslf_engine.
`timescale 1ns / 1ps

// Curves of a batch are taken one item at a time; the block is not ready while it
// works on an item. Storing a curve searches the table of distinct points seen so
// far in the batch one entry at a time, each entry read and then compared. The item
// marked last then starts the batch run: a selection sort that scans all stored
// slots once per kept edge and once more to finish, a union pass and a labeling
// pass whose root walks read the parent memory one step at a time, and one result
// per curve in input order. Batch state is cleared together with the final result,
// so no clearing pass follows reset or a batch.
module kruskal_spanning_forest_labeler_top #(
    parameter int MAX_EDGES = kslf_pkg::MAX_EDGES_DEF,
    parameter int MAX_NODES = kslf_pkg::MAX_NODES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96], edge_length[159:128]
    input  logic [kslf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // curve_absent[0]
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // curve_index[5:0], component_id[12:6], zero[15:13]
    output logic [kslf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // overflow_flag[0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    kslf_pkg::curve_t  in_item;
    kslf_pkg::result_t res;
    logic              res_ready;
    logic                          out_valid_reg;
    logic [kslf_pkg::IDX_W-1:0]    out_index_reg;
    logic [kslf_pkg::LBL_W-1:0]    out_label_reg;
    logic                          out_ovf_reg;
    logic                          out_last_reg;

    assign in_item.start_x      = s_axis_tdata[31:0];
    assign in_item.start_y      = s_axis_tdata[63:32];
    assign in_item.end_x        = s_axis_tdata[95:64];
    assign in_item.end_y        = s_axis_tdata[127:96];
    assign in_item.edge_length  = s_axis_tdata[159:128];
    assign in_item.curve_absent = s_axis_tuser;
    assign in_item.last_curve   = s_axis_tlast;

    kslf_engine #(
        .MAX_EDGES(MAX_EDGES),
        .MAX_NODES(MAX_NODES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .res_ready(res_ready),
        .res      (res)
    );

    // The result register lets the engine hand over a result while the last one leaves.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            out_index_reg <= res.curve_index;
            out_label_reg <= res.component_id;
            out_ovf_reg   <= res.overflow_flag;
            out_last_reg  <= res.last_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_label_reg, out_index_reg};
    assign m_axis_tuser  = out_ovf_reg;
    assign m_axis_tlast  = out_last_reg;

    // The engine never produces a result while it is open for a new curve.
    a_no_result_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !s_axis_tready)
        else $error("result produced while input side ready");

    // A label never exceeds the curve capacity MAX_EDGES.
    a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12:6] <= kslf_pkg::LBL_W'(MAX_EDGES)))
        else $error("component label out of range");

    // The engine hands over a result only when the result register can take it.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !res.valid)
        else $error("result overran a stalled output register");

endmodule
